// File: rtl/bounded_fifo_queue_unit_assert.svh
// assertion macros for the bounded fifo queue unit
`ifndef BOUNDED_FIFO_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_FIFO_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BFQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfq assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BFQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfq assertion failed");

`endif

// File: rtl/bfq_pkg.sv
// package with constants, codes and types of the bounded fifo queue unit
`default_nettype none

package bfq_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 8;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 8;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_PUSH  = 2'd0;
  localparam mode_t MODE_POP   = 2'd1;
  localparam mode_t MODE_QUERY = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bfq_cell.sv
// one storage cell of the queue chain: loads on push, takes its neighbor on pop
`default_nettype none

module bfq_cell (
  input  wire                          clk,
  input  bfq_pkg::cell_ctl_t           ctl,
  input  wire  [bfq_pkg::DATA_W-1:0]   next_data,
  input  wire  [bfq_pkg::DATA_W-1:0]   load_data,
  output logic [bfq_pkg::DATA_W-1:0]   data
);

  logic [bfq_pkg::DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= next_data;
    end else if (ctl.load) begin
      data_r <= load_data;
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: rtl/bounded_fifo_queue_unit.sv
// top level of the bounded fifo queue unit: control, cell chain and result register
// Usage:
//   in_*  : one request per accepted beat; in_tuser carries the operation
//           (push, pop, status query; code three acts as a query) and
//           in_tdata the value to push.
//   out_* : one result per request, in request order: status code in
//           out_tuser, popped value, occupancy, empty flag, front and rear
//           values in out_tdata.
//   cfg_* : capacity register, written whenever cfg_wr_en is high; values
//           above 128 act as 128, zero refuses every push.
// Latency: the result of a request is on out_* the cycle after acceptance.
// Throughput: one request per cycle while the result register is empty or
//   being drained; the cell chain does the whole operation (a pop shifts every cell toward the head).
// Stall: a result stays registered until out_tready; in_tready stays high
//   while the result register is empty or being drained.
// Reset: synchronous rst_n clears the occupancy and the result valid and
//   sets the capacity to 128; cell contents need no reset.
`default_nettype none
`include "bounded_fifo_queue_unit_assert.svh"

module bounded_fifo_queue_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,     // [7:0] push_value
  input  wire  [1:0]  in_tuser,     // [1:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,    // [7:0] popped_value, [15:8] occupancy,
                                    // [16] is_empty, [24:17] front_value,
                                    // [32:25] rear_value, [39:33] zero
  output logic [1:0]  out_tuser,    // [1:0] status
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data   // [7:0] capacity
);

  localparam int DEPTH  = bfq_pkg::DEPTH;
  localparam int DATA_W = bfq_pkg::DATA_W;
  localparam int CNT_W  = bfq_pkg::CNT_W;

  logic [bfq_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          eff_cap;
  logic [DATA_W-1:0]         rear_r;

  logic                      in_fire;
  logic                      is_push;
  logic                      is_pop;
  logic                      full;
  logic                      push_ok;
  logic                      pop_ok;
  bfq_pkg::mode_t            mode;
  logic [DATA_W-1:0]         push_val;

  logic [DATA_W-1:0]         chain [0:DEPTH];

  bfq_pkg::status_t          status_nxt;
  logic [DATA_W-1:0]         popped_nxt;
  logic [DATA_W-1:0]         front_nxt;
  logic [DATA_W-1:0]         rear_nxt;

  logic                      out_valid_r;
  bfq_pkg::status_t          out_status_r;
  logic [DATA_W-1:0]         out_popped_r;
  logic [CNT_W-1:0]          out_occ_r;
  logic                      out_is_empty_r;
  logic [DATA_W-1:0]         out_front_r;
  logic [DATA_W-1:0]         out_rear_r;

  assign mode     = in_tuser;
  assign push_val = in_tdata[DATA_W-1:0];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    case (mode)
      bfq_pkg::MODE_PUSH: is_push = 1'b1;
      bfq_pkg::MODE_POP:  is_pop  = 1'b1;
      default:            ;
    endcase
  end

  assign eff_cap = (cap_r > bfq_pkg::CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign full    = count_r >= eff_cap;
  assign push_ok = in_fire && is_push && !full;
  assign pop_ok  = in_fire && is_pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // cell chain, the slot past the tail reads zero
  assign chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bfq_pkg::cell_ctl_t ctl;
    assign ctl.shift = pop_ok;
    assign ctl.load  = push_ok && (count_r == CNT_W'(i));
    bfq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .next_data (chain[i+1]),
      .load_data (push_val),
      .data      (chain[i])
    );
  end

  always_comb begin
    status_nxt = bfq_pkg::ST_OK;
    if (is_push && full) begin
      status_nxt = bfq_pkg::ST_FULL;
    end else if (is_pop && (count_r == '0)) begin
      status_nxt = bfq_pkg::ST_EMPTY;
    end
    popped_nxt = pop_ok ? chain[0] : '0;
    if (count_nxt == '0) begin
      front_nxt = '0;
      rear_nxt  = '0;
    end else begin
      if (pop_ok) begin
        front_nxt = chain[1];
      end else if (push_ok && (count_r == '0)) begin
        front_nxt = push_val;
      end else begin
        front_nxt = chain[0];
      end
      rear_nxt = push_ok ? push_val : rear_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bfq_pkg::CAP_W'(128);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push_ok) begin
      rear_r <= push_val;
    end
    if (in_fire) begin
      out_status_r   <= status_nxt;
      out_popped_r   <= popped_nxt;
      out_occ_r      <= count_nxt;
      out_is_empty_r <= (count_nxt == '0);
      out_front_r    <= front_nxt;
      out_rear_r     <= rear_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_rear_r, out_front_r, out_is_empty_r,
                       out_occ_r, out_popped_r};

  `BFQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `BFQ_ASSERT_NXT(a_full_hold, in_fire && is_push && full, $stable(count_r))
  `BFQ_ASSERT_NXT(a_pop_dec, pop_ok, count_r == $past(count_r) - CNT_W'(1))
  `BFQ_ASSERT_IMP(a_empty_flag, out_valid_r, out_is_empty_r == (out_occ_r == '0))

endmodule

`default_nettype wire
